// ===== rtl/ptt_pkg.sv =====
`default_nettype none
package ptt_pkg;

  // Field and counter widths
  localparam int DIM_W     = 13;
  localparam int COORD_W   = 12;
  localparam int MAX_DIM   = 4096;
  localparam int ADDR_W    = 32;
  localparam int BYTE_W    = 3;
  localparam int ES_W      = 4;
  localparam int MAX_ES    = 8;
  localparam int PERM_W    = 8;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int OS1_W     = 2 * COORD_W + 1;

  // Word queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Cycles for the stride pipeline to settle after a register write
  localparam int SETTLE_W   = 2;
  localparam int CFG_SETTLE = 3;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM0 = 3'd0,
    CFG_DIM1 = 3'd1,
    CFG_DIM2 = 3'd2,
    CFG_DIM3 = 3'd3,
    CFG_PERM = 3'd4,
    CFG_ELEM = 3'd5
  } cfg_idx_t;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Effective settings seen by the front
  typedef struct packed {
    dim_t [3:0]             dim;
    logic [3:0][1:0]        ax;
    logic [ES_W-1:0]        es;
    logic                   settling;
  } cfg_view_t;

  // One classified byte on its way to the back
  typedef struct packed {
    coord_t [3:0]           pc;
    logic [BYTE_W-1:0]      bidx;
    logic [DATA_W-1:0]      data;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic [FIFO_AW:0]       count;
    logic                   full;
    logic                   empty;
  } fifo_stat_t;

  // Zero reads as one, oversize saturates
  function automatic dim_t eff_dim(input logic [DIM_W-1:0] d);
    dim_t r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [ES_W-1:0] eff_es(input logic [ES_W-1:0] e);
    logic [ES_W-1:0] r;
    if (e == '0) begin
      r = ES_W'(1);
    end else if (e > ES_W'(MAX_ES)) begin
      r = ES_W'(MAX_ES);
    end else begin
      r = e;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ptt_cfg.sv =====
`default_nettype none
module ptt_cfg
  import ptt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_wdata,
  output cfg_view_t                 view,
  output addr_t [3:0]               ss
);

  logic [DIM_W-1:0]  dim_reg [4];
  logic [PERM_W-1:0] perm_reg;
  logic [ES_W-1:0]   es_reg;
  logic [SETTLE_W-1:0] settle;

  dim_t [3:0]        id;
  dim_t [3:0]        od;
  logic [3:0][1:0]   ax;
  logic [ES_W-1:0]   es;
  logic [2*DIM_W-1:0] p1;
  logic [OS1_W+DIM_W-1:0] p0;
  logic [OS1_W-1:0]  os1;
  addr_t             os0;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg[0] <= DIM_W'(1);
      dim_reg[1] <= DIM_W'(1);
      dim_reg[2] <= DIM_W'(1);
      dim_reg[3] <= DIM_W'(1);
      perm_reg   <= PERM_W'(228);
      es_reg     <= ES_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIM0: dim_reg[0] <= cfg_wdata;
        CFG_DIM1: dim_reg[1] <= cfg_wdata;
        CFG_DIM2: dim_reg[2] <= cfg_wdata;
        CFG_DIM3: dim_reg[3] <= cfg_wdata;
        CFG_PERM: perm_reg   <= cfg_wdata[PERM_W-1:0];
        CFG_ELEM: es_reg     <= cfg_wdata[ES_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off input while strides settle
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else if (cfg_we) begin
      settle <= SETTLE_W'(CFG_SETTLE);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // Effective dims and permuted dims
  always_comb begin
    es = eff_es(es_reg);
    for (int i = 0; i < 4; i++) begin
      id[i] = eff_dim(dim_reg[i]);
      ax[i] = perm_reg[2*i +: 2];
    end
    for (int k = 0; k < 4; k++) begin
      od[k] = id[ax[k]];
    end
    p1 = (2*DIM_W)'(od[3]) * (2*DIM_W)'(od[2]);
    p0 = (OS1_W+DIM_W)'(os1) * (OS1_W+DIM_W)'(od[1]);
  end

  // Stride chain, one multiply per stage, then scale by element size
  always_ff @(posedge clk) begin
    os1   <= p1[OS1_W-1:0];
    os0   <= p0[ADDR_W-1:0];
    ss[3] <= ADDR_W'(es);
    ss[2] <= ADDR_W'(od[3]) * ADDR_W'(es);
    ss[1] <= ADDR_W'(os1) * ADDR_W'(es);
    ss[0] <= os0 * ADDR_W'(es);
  end

  assign view.dim      = id;
  assign view.ax       = ax;
  assign view.es       = es;
  assign view.settling = (settle != '0);

endmodule
`default_nettype wire

// ===== rtl/ptt_front.sv =====
`default_nettype none
module ptt_front
  import ptt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,
  input  wire cfg_view_t         view,
  input  wire logic              q_full,
  output logic                   push,
  output item_t                  item
);

  coord_t [3:0]      coord;
  coord_t [3:0]      coord_next;
  logic [BYTE_W-1:0] bidx;
  logic [BYTE_W-1:0] bidx_next;
  logic              wrap_b;
  logic [3:0]        wrap_c;
  logic              carry;

  assign s_tready = !q_full && !view.settling;
  assign push     = s_tvalid && s_tready;

  // Wrap tests; a counter at or past its limit counts as at the limit
  always_comb begin
    wrap_b = (ES_W'(bidx) + ES_W'(1)) >= view.es;
    for (int i = 0; i < 4; i++) begin
      wrap_c[i] = (DIM_W'(coord[i]) + DIM_W'(1)) >= view.dim[i];
    end
  end

  // Classify the word: permuted coordinates, byte index, last flag
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      item.pc[k] = coord[view.ax[k]];
    end
    item.bidx = bidx;
    item.data = s_tdata;
    item.last = wrap_b && (&wrap_c);
  end

  // Byte counter, then axis 3 fastest down to axis 0
  always_comb begin
    coord_next = coord;
    bidx_next  = bidx;
    carry      = 1'b0;
    if (push) begin
      bidx_next = wrap_b ? '0 : bidx + BYTE_W'(1);
      carry     = wrap_b;
      for (int i = 3; i >= 0; i--) begin
        if (carry) begin
          coord_next[i] = wrap_c[i] ? '0 : coord[i] + COORD_W'(1);
        end
        carry = carry && wrap_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coord <= '0;
      bidx  <= '0;
    end else begin
      coord <= coord_next;
      bidx  <= bidx_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ptt_fifo.sv =====
`default_nettype none
module ptt_fifo
  import ptt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wdata,
  input  wire logic  pop,
  output item_t      rdata,
  output fifo_stat_t stat
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

  assign rdata      = mem[rptr];
  assign stat.count = count;
  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

endmodule
`default_nettype wire

// ===== rtl/ptt_back.sv =====
`default_nettype none
module ptt_back
  import ptt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire item_t                    item,
  input  wire addr_t [3:0]              ss,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [ADDR_W+DATA_W-1:0]      m_tdata,
  output logic                          m_tlast
);

  logic              v1;
  addr_t [3:0]       prod;
  logic [BYTE_W-1:0] b1;
  logic [DATA_W-1:0] d1;
  logic              l1;

  logic              v2;
  addr_t             off2;
  logic [DATA_W-1:0] d2;
  logic              l2;

  logic              ready1;
  logic              ready2;
  addr_t             sum;

  assign ready2   = !v2 || m_tready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
    end
  end

  // Stage 1: coordinate times scaled stride, modulo 2^32
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= ADDR_W'(item.pc[k]) * ss[k];
      end
      b1 <= item.bidx;
      d1 <= item.data;
      l1 <= item.last;
    end
  end

  // Stage 2: sum of terms plus byte index into the output register
  assign sum = prod[0] + prod[1] + prod[2] + prod[3] + ADDR_W'(b1);

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      off2 <= sum;
      d2   <= d1;
      l2   <= l1;
    end
  end

  assign m_tvalid = v2;
  assign m_tdata  = {d2, off2};
  assign m_tlast  = l2;

endmodule
`default_nettype wire

// ===== rtl/tensor_permute_transpose_4d_top.sv =====
// Channel   Dir  Words                         tdata / tuser / tlast
// s_axis    in   one source byte               tdata[7:0] data_byte
// m_axis    out  one offset per source byte    tdata[31:0] dest_offset, [39:32] out_byte;
//                                              tlast final_byte
// cfg       in   register write, no read-back  cfg_index selects, cfg_wdata[12:0]
//
// One word per cycle sustained while m_tready is high and no register write is
// settling; m_tvalid rises once an accepted word has passed the queue write on the
// accepting edge, then the multiply stage and the sum stage. After any register write
// s_tready stays low while the stride multiply chain settles. Reset is synchronous
// and clears the counters. m_tready low fills the two back stages and then the
// four-word queue before s_tready drops.
`default_nettype none
module tensor_permute_transpose_4d_top
  import ptt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [DATA_W-1:0]    s_tdata,   // [7:0] data_byte
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [ADDR_W+DATA_W-1:0]  m_tdata,   // [31:0] dest_offset, [39:32] out_byte
  output logic                      m_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_wdata
);

  cfg_view_t   view;
  addr_t [3:0] ss;
  item_t       f_item;
  item_t       q_item;
  fifo_stat_t  q_stat;
  logic        push;
  logic        pop;
  logic        b_ready;

  ptt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .view      (view),
    .ss        (ss)
  );

  ptt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .view     (view),
    .q_full   (q_stat.full),
    .push     (push),
    .item     (f_item)
  );

  ptt_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (q_item),
    .stat  (q_stat)
  );

  assign pop = !q_stat.empty && b_ready;

  ptt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_stat.empty),
    .in_ready (b_ready),
    .item     (q_item),
    .ss       (ss),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_settle_block: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("word accepted while strides settle");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !q_stat.full)
    else $error("input ready with queue full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue fill level beyond depth");
`endif

endmodule
`default_nettype wire

// ===== sim/tensor_permute_transpose_4d_top_test.sv =====
module tensor_permute_transpose_4d_top_test;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_WORDS = 1800;
  localparam int CALM_WORDS   = 200;
  localparam int HOLD_CYCLES  = 64;
  localparam int SETTLE_EDGES = 8;
  localparam longint unsigned ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;

  // Indexes past the register map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

  typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

  // Directed row: a register write or a source byte, optionally with its result typed in
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;    // unused on word rows
    logic [DIM_W-1:0]       val;
    logic [DATA_W-1:0]      data;
    logic                   known;
    logic [ADDR_W-1:0]      off;
    logic                   fin;
  } dir_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  offset;
    logic [DATA_W-1:0]  byte_val;
    logic               last;
  } dest_word_t;

  localparam int N_DIRECTED = 36;
  dir_row_t directed_rows [N_DIRECTED] = '{
    // tensor of one byte after reset
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h00, 1'b1, 32'd0, 1'b1},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'hFF, 1'b1, 32'd0, 1'b1},
    // element size zero reads as one
    '{ROW_CFG,  CFG_ELEM, 13'd0,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h5A, 1'b1, 32'd0, 1'b1},
    // oversize element saturates to eight bytes
    '{ROW_CFG,  CFG_ELEM, 13'd15,   8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h01, 1'b1, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h80, 1'b1, 32'd1, 1'b0},
    // shrink the element mid-stream: byte index stays at two
    '{ROW_CFG,  CFG_ELEM, 13'd1,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h7E, 1'b1, 32'd2, 1'b1},
    // zero and oversize dims, reversed axes: offset = 3*c3 + c2
    '{ROW_CFG,  CFG_DIM0, 13'd0,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_DIM3, 13'd8191, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_DIM2, 13'd3,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_PERM, 13'h1B,   8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h11, 1'b1, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h22, 1'b1, 32'd3, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h33, 1'b1, 32'd6, 1'b0},
    // largest dims, maps with repeated axes
    '{ROW_CFG,  CFG_DIM0, 13'd4096, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_DIM1, 13'd4096, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_DIM2, 13'd4096, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_PERM, 13'hFF,   8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h44, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h55, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_PERM, 13'h00,   8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h66, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_ELEM, 13'd8,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h77, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h88, 1'b0, 32'd0, 1'b0},
    // writes past the map are ignored
    '{ROW_CFG,  CFG_UNMAPPED_A, 13'h1FFF, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_UNMAPPED_B, 13'h0AAA, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h99, 1'b0, 32'd0, 1'b0},
    // dims back to one with the axis-3 counter beyond its new limit
    '{ROW_CFG,  CFG_DIM0, 13'd1,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_DIM1, 13'd1,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_DIM2, 13'd1,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,  CFG_DIM3, 13'd1,    8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'hC3, 1'b0, 32'd0, 1'b0},
    '{ROW_WORD, CFG_DIM0, 13'd0,    8'h3C, 1'b0, 32'd0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata = '0;     // [7:0] data_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [ADDR_W+DATA_W-1:0] m_tdata;        // [31:0] dest_offset, [39:32] out_byte
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]       cfg_wdata = '0;

  // Register mirror, reset values; perm 228 is the identity map
  dim_t              reg_dim [4] = '{13'd1, 13'd1, 13'd1, 13'd1};
  logic [PERM_W-1:0] reg_perm = 8'd228;
  logic [ES_W-1:0]   reg_elem = 4'd1;

  // Counter mirror
  coord_t            coord [4] = '{12'd0, 12'd0, 12'd0, 12'd0};
  logic [BYTE_W-1:0] byte_idx = '0;

  dest_word_t pending_dest [$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  sink_stall = 0;
  int  hold_cnt = 0;
  bit  hold_req = 1'b0;
  bit  calm = 1'b0;

  tensor_permute_transpose_4d_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Destination offset of the current byte, then step the counters
  function automatic dest_word_t place_byte(input logic [DATA_W-1:0] b);
    longint unsigned in_dim [4];
    longint unsigned out_dim [4];
    longint unsigned ostride [4];
    longint unsigned crd [4];
    logic [1:0]      src_ax [4];
    longint unsigned es;
    longint unsigned dst;
    logic            carry;
    dest_word_t      w;
    es = (reg_elem == '0) ? 1 : (reg_elem > MAX_ES) ? MAX_ES : reg_elem;
    for (int a = 0; a < 4; a++) begin
      in_dim[a] = (reg_dim[a] == '0) ? 1 : (reg_dim[a] > MAX_DIM) ? MAX_DIM : reg_dim[a];
      crd[a] = coord[a];
    end
    for (int k = 0; k < 4; k++) begin
      src_ax[k] = reg_perm[2*k +: 2];
      out_dim[k] = in_dim[src_ax[k]];
    end
    // row-major strides of the permuted shape, in elements
    ostride[3] = 1;
    ostride[2] = out_dim[3];
    ostride[1] = (ostride[2] * out_dim[2]) & ADDR_MASK;
    ostride[0] = (ostride[1] * out_dim[1]) & ADDR_MASK;
    dst = 0;
    for (int k = 0; k < 4; k++)
      dst = (dst + ((crd[src_ax[k]] * ostride[k]) & ADDR_MASK)) & ADDR_MASK;
    w.offset   = ADDR_W'((dst * es + byte_idx) & ADDR_MASK);
    w.byte_val = b;
    w.last     = (byte_idx + 1 >= es);
    for (int a = 0; a < 4; a++)
      if (crd[a] + 1 < in_dim[a]) w.last = 1'b0;
    // byte within element, then axis 3 fastest; at-or-beyond limit wraps
    if (byte_idx + 1 >= es) begin
      byte_idx = '0;
      carry = 1'b1;
    end else begin
      byte_idx = byte_idx + 1'b1;
      carry = 1'b0;
    end
    for (int a = 3; a >= 0; a--) begin
      if (carry) begin
        if (crd[a] + 1 >= in_dim[a]) begin
          coord[a] = '0;
        end else begin
          coord[a] = coord[a] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    return w;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    case (idx)
      CFG_DIM0: reg_dim[0] = val;
      CFG_DIM1: reg_dim[1] = val;
      CFG_DIM2: reg_dim[2] = val;
      CFG_DIM3: reg_dim[3] = val;
      CFG_PERM: reg_perm = val[PERM_W-1:0];
      CFG_ELEM: reg_elem = val[ES_W-1:0];
      default: ;
    endcase
  endfunction

  // Register write once every offset in flight has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_dest.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  // Offer one source byte, optionally after a gap; queue its expected word
  task automatic send_word(input logic [DATA_W-1:0] b, input logic known,
                           input logic [ADDR_W-1:0] off, input logic fin);
    dest_word_t w;
    int         gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    cfg_we <= 1'b0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    w = place_byte(b);
    if (known) begin
      w.offset = off;
      w.last   = fin;
    end
    pending_dest.push_back(w);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_dest_word();
    dest_word_t want;
    if (pending_dest.size() == 0) begin
      report_mismatch($sformatf("unexpected word offset=%h byte=%h last=%b",
                                m_tdata[ADDR_W-1:0], m_tdata[ADDR_W +: DATA_W], m_tlast));
    end else begin
      want = pending_dest.pop_front();
      if (m_tdata[ADDR_W-1:0] !== want.offset)
        report_mismatch($sformatf("dest_offset exp %h got %h", want.offset,
                                  m_tdata[ADDR_W-1:0]));
      if (m_tdata[ADDR_W +: DATA_W] !== want.byte_val)
        report_mismatch($sformatf("out_byte exp %h got %h", want.byte_val,
                                  m_tdata[ADDR_W +: DATA_W]));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("final_byte exp %b got %b", want.last, m_tlast));
    end
  endtask

  // Receiver: check each word, stall in bursts, long hold-off on request
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) check_dest_word();
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else if (sink_stall != 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(1, 12) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    dir_row_t         row;
    int               sent;
    int               phase;
    int               phase_len;
    int               j;
    logic [1:0]       lanes [4];
    logic [1:0]       tmp;
    logic [DIM_W-1:0] dval;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) write_reg(row.idx, row.val);
      else send_word(row.data, row.known, row.off, row.fin);
    end

    // random phases: fresh settings between phases, counters left as they stand
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      calm = (sent >= RANDOM_WORDS - CALM_WORDS);
      for (int a = 0; a < 4; a++) begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 9))
            7: dval = '0;
            8: dval = DIM_W'($urandom_range(4, 12));
            9: dval = ($urandom_range(0, 2) == 0) ? DIM_W'(MAX_DIM) : DIM_W'($urandom);
            default: dval = DIM_W'($urandom_range(1, 3));
          endcase
          write_reg(CFG_DIM0 + CFG_IDX_W'(a), dval);
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 3) == 0) begin
          dval = DIM_W'($urandom);
        end else begin
          lanes = '{2'd0, 2'd1, 2'd2, 2'd3};
          for (int i = 3; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = lanes[i];
            lanes[i] = lanes[j];
            lanes[j] = tmp;
          end
          dval = {5'b0, lanes[3], lanes[2], lanes[1], lanes[0]};
        end
        write_reg(CFG_PERM, dval);
      end
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: dval = DIM_W'($urandom);
          1: dval = '0;
          2: dval = DIM_W'($urandom_range(9, 15));
          default: dval = DIM_W'($urandom_range(1, 8));
        endcase
        write_reg(CFG_ELEM, dval);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(($urandom_range(0, 1) == 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
                  DIM_W'($urandom));

      // receiver holds off while bytes keep coming, filling the block
      if (phase == 1 || phase == 8) hold_req = 1'b1;
      phase_len = $urandom_range(16, 100);
      for (int n = 0; n < phase_len; n++) send_word(DATA_W'($urandom), 1'b0, '0, 1'b0);
      sent += phase_len;
      phase++;
    end
    s_tvalid <= 1'b0;

    while (pending_dest.size() != 0) @(posedge clk);
    repeat (SETTLE_EDGES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ptt_pkg.sv
rtl/ptt_cfg.sv
rtl/ptt_front.sv
rtl/ptt_fifo.sv
rtl/ptt_back.sv
rtl/tensor_permute_transpose_4d_top.sv
sim/tensor_permute_transpose_4d_top_test.sv
